// File: src/rvxu_pkg.sv
// ----------------------------------------------------------------------------
// rvxu_pkg
// Shared types, opcodes and field codes for the RV32I execute unit.
// ----------------------------------------------------------------------------
package rvxu_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_USED_W  = 137;
    localparam int REG_IDX_W   = 5;
    localparam int DEF_REG_COUNT = 32;

    // request kinds
    localparam logic REQ_EXEC = 1'b0;
    localparam logic REQ_LOAD_DATA = 1'b1;

    // major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    // whole system words
    localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INST_EBREAK = 32'h0010_0073;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // alu funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // load / store size funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    // byte enables
    localparam logic [3:0] STRB_BYTE = 4'b0001;
    localparam logic [3:0] STRB_HALF = 4'b0011;
    localparam logic [3:0] STRB_WORD = 4'b1111;

    // one request held in the execute stage
    typedef struct packed {
        logic        req_type;
        logic [31:0] instruction;
        logic [31:0] fetch_pc;
        logic [31:0] load_data;
        logic        rs1_ok;
        logic        rs2_ok;
    } item_t;

    // one result
    typedef struct packed {
        logic        taken;
        logic        jump_absolute;
        logic [31:0] branch_offset;
        logic [31:0] jalr_target;
        logic        mem_valid;
        logic        mem_store;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [3:0]  mem_strobe;
        logic        illegal;
    } result_t;

    // register file write-back
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [31:0]          data;
    } wb_t;

    // outstanding load
    typedef struct packed {
        logic                 load_pending;
        logic [REG_IDX_W-1:0] dest;
        logic [2:0]           size_code;
    } pend_t;

    // byte strobe from size funct3
    function automatic logic [3:0] size_strobe(input logic [2:0] f3);
        logic [3:0] s;
        case (f3[1:0])
            2'd0:    s = STRB_BYTE;
            2'd1:    s = STRB_HALF;
            default: s = STRB_WORD;
        endcase
        return s;
    endfunction

endpackage

// File: src/rvxu_regfile.sv
// ----------------------------------------------------------------------------
// rvxu_regfile
// Integer register file: two synchronous read ports with write bypass.
// ----------------------------------------------------------------------------
module rvxu_regfile #(
    parameter int REG_COUNT = rvxu_pkg::DEF_REG_COUNT
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr1,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr2,
    output logic [31:0]                  rd_data1,
    output logic [31:0]                  rd_data2,
    input  logic                         wr_en,
    input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
    input  logic [31:0]                  wr_data
);
    logic [31:0] mem [REG_COUNT];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports, a same-cycle write is passed straight through
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data1 <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
            rd_data2 <= (wr_en && wr_addr == rd_addr2) ? wr_data : mem[rd_addr2];
        end
    end

endmodule

// File: src/rvxu_exec.sv
// ----------------------------------------------------------------------------
// rvxu_exec
// Decode, ALU, branch compare, address generation and load extension.
// ----------------------------------------------------------------------------
module rvxu_exec #(
    parameter int REG_COUNT = rvxu_pkg::DEF_REG_COUNT
) (
    input  rvxu_pkg::item_t   item,
    input  logic [31:0]       rs1_data,
    input  logic [31:0]       rs2_data,
    input  rvxu_pkg::pend_t   pend,
    output rvxu_pkg::result_t res,
    output rvxu_pkg::wb_t     wb,
    output logic              pend_we,
    output rvxu_pkg::pend_t   pend_next
);
    import rvxu_pkg::*;

    logic [31:0] inst;
    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] alu_y;
    logic        alu_alt;
    logic [31:0] alu_out;
    logic [31:0] addr_sum;
    logic        br_cond;
    logic [31:0] ld_ext;
    logic        rd_ok;
    logic        pd_ok;

    // field split
    assign inst   = item.instruction;
    assign opcode = inst[6:0];
    assign rd     = inst[11:7];
    assign f3     = inst[14:12];
    assign f7     = inst[31:25];
    assign a      = item.rs1_ok ? rs1_data : 32'd0;
    assign b      = item.rs2_ok ? rs2_data : 32'd0;

    // immediates
    assign imm_i = {{20{inst[31]}}, inst[31:20]};
    assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
    assign imm_b = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
    assign imm_j = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
    assign imm_u = {inst[31:12], 12'd0};

    // destination indexes that really exist
    assign rd_ok = (rd != '0) && (32'(rd) < REG_COUNT);
    assign pd_ok = (pend.dest != '0) && (32'(pend.dest) < REG_COUNT);

    // alu
    assign alu_y   = (opcode == OP_REG) ? b : imm_i;
    assign alu_alt = (f7 == F7_ALT) && ((opcode == OP_REG) || (f3 == F3_SR));

    always_comb
    begin
        case (f3)
            F3_ADD:  alu_out = alu_alt ? a - alu_y : a + alu_y;
            F3_SLL:  alu_out = a << alu_y[4:0];
            F3_SLT:  alu_out = {31'd0, $signed(a) < $signed(alu_y)};
            F3_SLTU: alu_out = {31'd0, a < alu_y};
            F3_XOR:  alu_out = a ^ alu_y;
            F3_SR:   alu_out = alu_alt ? 32'($signed(a) >>> alu_y[4:0]) : a >> alu_y[4:0];
            F3_OR:   alu_out = a | alu_y;
            F3_AND:  alu_out = a & alu_y;
            default: alu_out = a & alu_y;
        endcase
    end

    // shared address adder for loads, stores and jalr
    assign addr_sum = a + ((opcode == OP_STORE) ? imm_s : imm_i);

    // branch condition
    always_comb
    begin
        case (f3)
            F3_BEQ:  br_cond = (a == b);
            F3_BNE:  br_cond = (a != b);
            F3_BLT:  br_cond = ($signed(a) < $signed(b));
            F3_BGE:  br_cond = ($signed(a) >= $signed(b));
            F3_BLTU: br_cond = (a < b);
            F3_BGEU: br_cond = (a >= b);
            default: br_cond = 1'b0;
        endcase
    end

    // load data extension
    always_comb
    begin
        case (pend.size_code)
            F3_LB:   ld_ext = {{24{item.load_data[7]}}, item.load_data[7:0]};
            F3_LH:   ld_ext = {{16{item.load_data[15]}}, item.load_data[15:0]};
            F3_LBU:  ld_ext = {24'd0, item.load_data[7:0]};
            F3_LHU:  ld_ext = {16'd0, item.load_data[15:0]};
            default: ld_ext = item.load_data;
        endcase
    end

    // per-opcode result, write-back and pending load update
    always_comb
    begin
        res       = '0;
        wb        = '0;
        pend_we   = 1'b0;
        pend_next = pend;
        if (item.req_type == REQ_LOAD_DATA)
        begin
            if (pend.load_pending)
            begin
                wb.en                  = pd_ok;
                wb.addr                = pend.dest;
                wb.data                = ld_ext;
                pend_we                = 1'b1;
                pend_next.load_pending = 1'b0;
            end
        end
        else
        begin
            case (opcode)
                OP_LUI:
                begin
                    wb = '{en: rd_ok, addr: rd, data: imm_u};
                end
                OP_AUIPC:
                begin
                    wb = '{en: rd_ok, addr: rd, data: item.fetch_pc + imm_u};
                end
                OP_JAL:
                begin
                    res.taken         = 1'b1;
                    res.branch_offset = imm_j;
                    wb = '{en: rd_ok, addr: rd, data: item.fetch_pc + 32'd4};
                end
                OP_JALR:
                begin
                    if (f3 != 3'd0)
                    begin
                        res.illegal = 1'b1;
                    end
                    else
                    begin
                        res.taken         = 1'b1;
                        res.jump_absolute = 1'b1;
                        res.jalr_target   = {addr_sum[31:1], 1'b0};
                        wb = '{en: rd_ok, addr: rd, data: item.fetch_pc + 32'd4};
                    end
                end
                OP_BRANCH:
                begin
                    if (f3 inside {3'd2, 3'd3})
                    begin
                        res.illegal = 1'b1;
                    end
                    else if (br_cond)
                    begin
                        res.taken         = 1'b1;
                        res.branch_offset = imm_b;
                    end
                end
                OP_LOAD:
                begin
                    if (f3 inside {3'd3, 3'd6, 3'd7})
                    begin
                        res.illegal = 1'b1;
                    end
                    else
                    begin
                        res.mem_valid  = 1'b1;
                        res.mem_addr   = addr_sum;
                        res.mem_strobe = size_strobe(f3);
                        pend_we        = 1'b1;
                        pend_next      = '{load_pending: 1'b1, dest: rd, size_code: f3};
                    end
                end
                OP_STORE:
                begin
                    if (f3 > F3_LW)
                    begin
                        res.illegal = 1'b1;
                    end
                    else
                    begin
                        res.mem_valid  = 1'b1;
                        res.mem_store  = 1'b1;
                        res.mem_addr   = addr_sum;
                        res.mem_wdata  = b;
                        res.mem_strobe = size_strobe(f3);
                    end
                end
                OP_IMM:
                begin
                    if ((f3 == F3_SLL && f7 != F7_BASE) ||
                        (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT))
                    begin
                        res.illegal = 1'b1;
                    end
                    else
                    begin
                        wb = '{en: rd_ok, addr: rd, data: alu_out};
                    end
                end
                OP_REG:
                begin
                    if (!(f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))))
                    begin
                        res.illegal = 1'b1;
                    end
                    else
                    begin
                        wb = '{en: rd_ok, addr: rd, data: alu_out};
                    end
                end
                OP_FENCE:
                begin
                    res.illegal = (f3 != 3'd0);
                end
                OP_SYSTEM:
                begin
                    res.illegal = (inst != INST_ECALL) && (inst != INST_EBREAK);
                end
                default:
                begin
                    res.illegal = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: src/rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// RV32I integer execute unit with a load data write-back path.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser carries the kind: an
//   instruction to execute (with its pc) or load data returning from memory
//   for the last issued load. Every request gives exactly one result on the
//   m_axis channel: control transfer, memory request and illegal flag.
//   Requests register in the execute stage, results in the output register.
//   One request per cycle unless stalled; the register file is a memory with
//   two registered read ports and one write port, read in the cycle a request
//   is taken and written back in the execute cycle, with a bypass in the read
//   port so back-to-back dependent requests see fresh values.
//   Stall: while a result waits on m_axis_tready the pipeline holds and
//   s_axis_tready is low; it goes high again in the cycle the result leaves.
//   Reset: clears the pipeline valid bits and the pending load. Registers
//   other than x0 are undefined until written; x0 always reads zero.
// ----------------------------------------------------------------------------
module rv32i_execute_unit #(
    parameter int REG_COUNT = rvxu_pkg::DEF_REG_COUNT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // instruction[31:0], fetch_pc[63:32], load_data[95:64]
    input  logic [rvxu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // taken[0], jump_absolute[1], branch_offset[33:2], jalr_target[65:34],
    // mem_valid[66], mem_store[67], mem_addr[99:68], mem_wdata[131:100],
    // mem_strobe[135:132], illegal[136], zero[143:137]
    output logic [rvxu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rvxu_pkg::*;

    localparam int REG_AW = $clog2(REG_COUNT);

    logic        adv;
    logic        accept;
    logic        s1_fire;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res_reg;
    result_t     res;
    wb_t         wb;
    logic        pend_we;
    pend_t       pend_next;
    pend_t       pend_reg;
    logic [4:0]  rs1_idx;
    logic [4:0]  rs2_idx;
    logic [31:0] rs1_data;
    logic [31:0] rs2_data;

    // handshake and pipeline advance
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign s1_fire       = s1_valid_reg && adv;
    assign s1_valid_next = adv ? accept : s1_valid_reg;
    assign out_valid_next = adv ? s1_valid_reg : out_valid_reg;

    // source indexes from the incoming word
    assign rs1_idx = s_axis_tdata[19:15];
    assign rs2_idx = s_axis_tdata[24:20];

    // register file
    rvxu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk      (clk),
        .rd_en    (adv),
        .rd_addr1 (rs1_idx[REG_AW-1:0]),
        .rd_addr2 (rs2_idx[REG_AW-1:0]),
        .rd_data1 (rs1_data),
        .rd_data2 (rs2_data),
        .wr_en    (s1_fire && wb.en),
        .wr_addr  (wb.addr[REG_AW-1:0]),
        .wr_data  (wb.data)
    );

    // execute
    rvxu_exec #(
        .REG_COUNT (REG_COUNT)
    ) u_exec (
        .item      (s1_item_reg),
        .rs1_data  (rs1_data),
        .rs2_data  (rs2_data),
        .pend      (pend_reg),
        .res       (res),
        .wb        (wb),
        .pend_we   (pend_we),
        .pend_next (pend_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire && pend_we)
            begin
                pend_reg <= pend_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.req_type    <= s_axis_tuser[0];
            s1_item_reg.instruction <= s_axis_tdata[31:0];
            s1_item_reg.fetch_pc    <= s_axis_tdata[63:32];
            s1_item_reg.load_data   <= s_axis_tdata[95:64];
            s1_item_reg.rs1_ok      <= (rs1_idx != '0) && (32'(rs1_idx) < REG_COUNT);
            s1_item_reg.rs2_ok      <= (rs2_idx != '0) && (32'(rs2_idx) < REG_COUNT);
        end
        if (s1_fire)
        begin
            res_reg <= res;
        end
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - OUT_USED_W)'(0),
        res_reg.illegal,
        res_reg.mem_strobe,
        res_reg.mem_wdata,
        res_reg.mem_addr,
        res_reg.mem_store,
        res_reg.mem_valid,
        res_reg.jalr_target,
        res_reg.branch_offset,
        res_reg.jump_absolute,
        res_reg.taken
    };

    // checks
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && wb.en) |-> (wb.addr != '0))
        else $error("write-back to x0");

    a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res.illegal) |-> (!res.mem_valid && !res.taken && !wb.en && !pend_we))
        else $error("illegal request has side effects");

    a_load_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res.mem_valid && !res.mem_store) |=> pend_reg.load_pending)
        else $error("load request did not record a pending load");

    a_abs_implies_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res.jump_absolute) |-> res.taken)
        else $error("absolute jump without taken");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && s1_valid_reg) |=> s1_valid_reg)
        else $error("execute stage lost a request during a stall");

endmodule
